// File: design/tsge_pkg.sv
// ----------------------------------------------------------------------------
// tsge_pkg
// Shared constants, types and tables of the two-state ground energy pipeline.
// ----------------------------------------------------------------------------
package tsge_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned HORNER_TERMS = 9;
  localparam int unsigned SQRT_STAGES  = 16;
  localparam int unsigned NSTAGE       = 53;

  localparam logic [30:0] ONE_Q30   = 31'(64'd1 << 30);
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [22:0] EXP_CAP   = 23'(64'd64 << FRAC_BITS);

  typedef enum logic [1:0] {
    REG_PEAK  = 2'd0,
    REG_WIDTH = 2'd1,
    REG_REF   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  // floor(2^34 / k) for the Horner divisors one to nine.
  function automatic logic [34:0] horner_recip(input logic [3:0] k);
    logic [34:0] m;
    case (k)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623061;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973836;
      4'd6:    m = 35'd2863311530;
      4'd7:    m = 35'd2454267026;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874353;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

endpackage

// File: design/tsge_if.sv
// ----------------------------------------------------------------------------
// tsge_in_if / tsge_out_if
// Valid/ready channels for points in and ground energies out.
// ----------------------------------------------------------------------------
interface tsge_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] energy_a;
  logic [31:0] energy_b;
  logic [31:0] coord;
  logic        last_point;
  modport source (output valid, energy_a, energy_b, coord, last_point, input ready);
  modport sink   (input valid, energy_a, energy_b, coord, last_point, output ready);
endinterface

interface tsge_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ground_energy;
  logic [31:0] coord_out;
  logic        last_out;
  modport source (output valid, ground_energy, coord_out, last_out, input ready);
  modport sink   (input valid, ground_energy, coord_out, last_out, output ready);
endinterface

// File: design/tsge_horner_step.sv
// ----------------------------------------------------------------------------
// tsge_horner_step
// One Horner term of exp(-t): p' = 2^30 - ((t * p) >> 30) / k, three stages.
// ----------------------------------------------------------------------------
module tsge_horner_step import tsge_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  adv,
  input  logic [29:0] t_in,
  input  logic [30:0] p_in,
  input  logic [3:0]  k,
  input  logic [34:0] recip,
  output logic [29:0] t_out,
  output logic [30:0] p_out
);

  logic [60:0] tp;
  logic [65:0] qm;
  logic [30:0] v_a, v_b, q0_b, q;
  logic [31:0] rem;
  logic [29:0] t_a, t_b;

  assign tp = 61'(t_in) * 61'(p_in);
  assign qm = 66'(v_a) * 66'(recip);

  // The reciprocal quotient is at most one short; one compare fixes it.
  assign rem = 32'(v_b) - 32'(q0_b) * 32'(k);
  assign q   = (rem >= 32'(k)) ? q0_b + 31'd1 : q0_b;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      v_a <= tp[60:30];
      t_a <= t_in;
    end
    if (adv[1]) begin
      q0_b <= qm[64:34];
      v_b  <= v_a;
      t_b  <= t_a;
    end
    if (adv[2]) begin
      p_out <= ONE_Q30 - q;
      t_out <= t_b;
    end
  end

endmodule

// File: design/two_state_ground_energy.sv
// ----------------------------------------------------------------------------
// two_state_ground_energy
// Lower eigenvalue of a two-state valence bond model, one point per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Points arrive on the valid/ready channel "point" (energy_a, energy_b,
// coord, last_point) and each gives one request on "result"
// (ground_energy, coord_out, last_out), in order.
// The pipeline has 53 register stages. A new point is taken every cycle
// while the output is not stalled; the rate is set by the ready chain,
// which lets each stage load whenever it is empty or its successor moves.
// The longest run of stages is the nine-term Horner evaluation of exp,
// three stages a term, and the square root, two result bits a stage.
// When the receiver stalls, the stages fill up behind the output register
// and point.ready falls only once every stage holds a point.
// Synchronous reset empties the pipeline and sets coupling_peak and
// coupling_width to 6554 and ref_coord to 0. The APB registers sit at byte
// addresses 0, 4 and 8 and should be written only while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module two_state_ground_energy import tsge_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tsge_in_if.sink     point,
  tsge_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned S_DIFF = 1;
  localparam int unsigned S_SQ   = 2;
  localparam int unsigned S_PART = 3;
  localparam int unsigned S_X    = 4;
  localparam int unsigned S_Y    = 5;
  localparam int unsigned S_T    = 6;
  localparam int unsigned S_H0   = 7;
  localparam int unsigned S_EXP  = S_H0 + 3 * HORNER_TERMS;
  localparam int unsigned S_V2   = S_EXP + 1;
  localparam int unsigned S_RAD  = S_V2 + 1;
  localparam int unsigned S_RT0  = S_RAD + 1;
  localparam int unsigned S_OUT  = S_RT0 + SQRT_STAGES;

  // Configuration registers.
  logic [31:0] coupling_peak, coupling_width, ref_coord;
  cfg_reg_t    cfg_sel;

  assign cfg_sel = cfg_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_peak  <= 32'd6554;
      coupling_width <= 32'd6554;
      ref_coord      <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        REG_PEAK:  coupling_peak  <= pwdata;
        REG_WIDTH: coupling_width <= pwdata;
        REG_REF:   ref_coord      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PEAK:  prdata = coupling_peak;
      REG_WIDTH: prdata = coupling_width;
      REG_REF:   prdata = ref_coord;
      default:   prdata = 32'd0;
    endcase
  end

  // Valid bits and the ready chain.
  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] rdy;

  assign rdy[NSTAGE+1] = result.ready;
  for (genvar k = 1; k <= NSTAGE; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= point.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign point.ready = rdy[1];

  // Fields that ride along the pipeline: coord, last and the energy sum over every stage, the rest over part of it.
  logic [31:0]        coord_p [1:NSTAGE];
  logic               last_p  [1:NSTAGE];
  logic signed [32:0] sume_p  [1:NSTAGE];
  logic [63:0]        dsq_p   [S_SQ:S_V2];
  logic [7:0]         n_p     [S_T:S_EXP-1];
  logic               ovf_p   [S_RAD:S_OUT-1];
  sqrt_st_t           sq_p    [S_RAD:S_OUT-1];

  // Stage 1: differences and the energy sum.
  logic signed [32:0] dq, de;
  logic [31:0]        dm1, dd1;

  assign dq = $signed({point.coord[31], point.coord}) - $signed({ref_coord[31], ref_coord});
  assign de = $signed({point.energy_a[31], point.energy_a})
            - $signed({point.energy_b[31], point.energy_b});

  always_ff @(posedge clk) begin
    if (rdy[S_DIFF]) begin
      dm1 <= dq[32] ? 32'(-dq) : dq[31:0];
      dd1 <= de[32] ? 32'(-de) : de[31:0];
      coord_p[S_DIFF] <= point.coord;
      last_p[S_DIFF]  <= point.last_point;
      sume_p[S_DIFF]  <= $signed({point.energy_a[31], point.energy_a})
                       + $signed({point.energy_b[31], point.energy_b});
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (rdy[k]) begin
        coord_p[k] <= coord_p[k-1];
        last_p[k]  <= last_p[k-1];
        sume_p[k]  <= sume_p[k-1];
      end
    end
  end

  // Stage 2: squares.
  logic [63:0] dm_sq;
  logic [47:0] sq2;

  assign dm_sq = 64'(dm1) * 64'(dm1);

  always_ff @(posedge clk) begin
    if (rdy[S_SQ]) begin
      sq2         <= dm_sq[FRAC_BITS +: 48];
      dsq_p[S_SQ] <= 64'(dd1) * 64'(dd1);
    end
    for (int k = S_SQ + 1; k <= S_V2; k++) begin
      if (rdy[k]) dsq_p[k] <= dsq_p[k-1];
    end
  end

  // Stage 3: alpha * sq in two partial products. A large sq clamps unless the width is zero.
  logic [50:0] ph3, pl3;
  logic        big3;

  always_ff @(posedge clk) begin
    if (rdy[S_PART]) begin
      big3 <= (|sq2[47:38]) && (coupling_width != 32'd0);
      ph3  <= 51'(coupling_width) * 51'(sq2[37:19]);
      pl3  <= 51'(coupling_width) * 51'(sq2[18:0]);
    end
  end

  // Stage 4: exponent argument, clamped.
  logic [69:0] prod4;
  logic [53:0] xraw;
  logic [22:0] x4;

  assign prod4 = {ph3, 19'd0} + 70'(pl3);
  assign xraw  = prod4[FRAC_BITS +: 54];

  always_ff @(posedge clk) begin
    if (rdy[S_X]) begin
      x4 <= (big3 || xraw > 54'(EXP_CAP)) ? EXP_CAP : xraw[22:0];
    end
  end

  // Stage 5: convert to a power of two.
  logic [53:0] ymul;
  logic [23:0] y5;

  assign ymul = 54'(x4) * 54'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (rdy[S_Y]) y5 <= ymul[53:30];
  end

  // Stage 6: split into integer shift and fractional part back in natural log.
  logic [29:0] g6;
  logic [59:0] tmul;
  logic [29:0] t6;

  assign g6   = {y5[FRAC_BITS-1:0], 14'd0};
  assign tmul = 60'(g6) * 60'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (rdy[S_T]) begin
      t6       <= tmul[59:30];
      n_p[S_T] <= y5[23:FRAC_BITS];
    end
    for (int k = S_T + 1; k <= S_EXP - 1; k++) begin
      if (rdy[k]) n_p[k] <= n_p[k-1];
    end
  end

  // Stages 7 to 33: Horner terms for k from nine down to one.
  logic [29:0] t_h [0:HORNER_TERMS];
  logic [30:0] p_h [0:HORNER_TERMS];

  assign t_h[0] = t6;
  assign p_h[0] = ONE_Q30;

  for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_horner
    tsge_horner_step u_step (
      .clk   (clk),
      .adv   (rdy[S_H0 + 3*j +: 3]),
      .t_in  (t_h[j]),
      .p_in  (p_h[j]),
      .k     (4'(HORNER_TERMS - j)),
      .recip (horner_recip(4'(HORNER_TERMS - j))),
      .t_out (t_h[j+1]),
      .p_out (p_h[j+1])
    );
  end

  // Stage 34: scale by the power of two.
  logic [30:0] e34;

  always_ff @(posedge clk) begin
    if (rdy[S_EXP]) begin
      e34 <= (n_p[S_EXP-1] > 8'd30) ? 31'd0 : p_h[HORNER_TERMS] >> n_p[S_EXP-1];
    end
  end

  // Stage 35: squared coupling.
  logic [62:0] vmul;
  logic [31:0] v2;

  assign vmul = 63'(coupling_peak) * 63'(e34);

  always_ff @(posedge clk) begin
    if (rdy[S_V2]) v2 <= vmul[61:30];
  end

  // Stage 36: radicand. When it passes 64 bits, both terms are quartered.
  logic [63:0] cterm, alt;
  logic [64:0] rsum;

  assign cterm = 64'(v2) << (FRAC_BITS + 2);
  assign rsum  = 65'(dsq_p[S_V2]) + 65'(cterm);
  assign alt   = (dsq_p[S_V2] >> 2) + (cterm >> 2);

  always_ff @(posedge clk) begin
    if (rdy[S_RAD]) begin
      ovf_p[S_RAD]      <= rsum[64];
      sq_p[S_RAD].rem  <= rsum[64] ? alt : rsum[63:0];
      sq_p[S_RAD].root <= 32'd0;
    end
  end

  // Stages 37 to 52: square root, two result bits per stage.
  function automatic sqrt_st_t sqrt_pair(input sqrt_st_t cur, input int unsigned hi);
    sqrt_st_t    nx;
    logic [65:0] trial;
    nx = cur;
    for (int b = 0; b < 2; b++) begin
      trial = (66'(nx.root) << (hi - b + 1)) + (66'd1 << (2 * (hi - b)));
      if (66'(nx.rem) >= trial) begin
        nx.rem  = nx.rem - trial[63:0];
        nx.root = nx.root | (32'd1 << (hi - b));
      end
    end
    return nx;
  endfunction

  for (genvar m = 0; m < SQRT_STAGES; m++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rdy[S_RT0 + m]) begin
        sq_p[S_RT0 + m]  <= sqrt_pair(sq_p[S_RT0 + m - 1], 31 - 2 * m);
        ovf_p[S_RT0 + m] <= ovf_p[S_RT0 + m - 1];
      end
    end
  end

  // Stage 53: halve and saturate.
  sqrt_st_t           sq_last;
  logic [33:0]        s_root;
  logic signed [34:0] diff;
  logic signed [33:0] half;
  logic [31:0]        ge53;

  assign sq_last = sq_p[S_OUT-1];
  assign s_root  = ovf_p[S_OUT-1] ? {1'b0, sq_last.root, 1'b0} : {2'b0, sq_last.root};
  assign diff    = 35'(sume_p[S_OUT-1]) - $signed({1'b0, s_root});
  assign half    = diff[34:1];

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      if (half > 34'sh07FFFFFFF) begin
        ge53 <= 32'h7FFFFFFF;
      end else if (half < -34'sh080000000) begin
        ge53 <= 32'h80000000;
      end else begin
        ge53 <= half[31:0];
      end
    end
  end

  assign result.valid         = vld[NSTAGE];
  assign result.ground_energy = ge53;
  assign result.coord_out     = coord_p[NSTAGE];
  assign result.last_out      = last_p[NSTAGE];

endmodule

// File: design/tsge_checker.sv
// ----------------------------------------------------------------------------
// tsge_checker
// Port-level checks of the ground energy pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tsge_checker (
  input logic        clk,
  input logic        rst,
  input logic        pt_ready,
  input logic        rs_valid,
  input logic        rs_ready,
  input logic [31:0] rs_energy,
  input logic        pready
);

  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rs_valid)
    else $error("result valid right after reset");

  // With the output free, nothing in the pipeline may hold up a new point.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (rs_ready || !rs_valid) |-> pt_ready)
    else $error("point stalled while output is free");

  // A stalled request keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rs_valid && !rs_ready |=> rs_valid && $stable(rs_energy))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind two_state_ground_energy tsge_checker u_tsge_checker (
  .clk       (clk),
  .rst       (rst),
  .pt_ready  (point.ready),
  .rs_valid  (result.valid),
  .rs_ready  (result.ready),
  .rs_energy (result.ground_energy),
  .pready    (pready)
);

// File: tb/two_state_ground_energy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_state_ground_energy_tb
// Streams points through the ground energy pipeline under several coupling
// settings and backpressure patterns. Each result is compared against a
// bit-accurate fixed-point prediction of the lower adiabatic energy.
// ----------------------------------------------------------------------------
module two_state_ground_energy_tb;
  import tsge_pkg::*;

  typedef struct {
    logic [31:0] ground;
    logic [31:0] coord;
    logic        last;
  } energy_exp_t;

  class energy_scoreboard;
    logic [31:0] peak;
    logic [31:0] width;
    logic [31:0] ref_q;
    energy_exp_t pending[$];
    int          errors;

    function new();
      peak   = 32'd6554;
      width  = 32'd6554;
      ref_q  = 32'd0;
      errors = 0;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // exp(-x) in Q30 for x in Q16.16, by base-2 split and a Horner series.
    function automatic logic [63:0] decay_q30(input logic [63:0] x);
      logic [63:0] y, n, g, t, p;
      logic [127:0] wide;
      wide = 128'(x) * 128'(LOG2E_Q30);
      y    = 64'(wide >> 30);
      n    = y >> FRAC_BITS;
      g    = (y & ((64'd1 << FRAC_BITS) - 1)) << (30 - FRAC_BITS);
      t    = (g * 64'(LN2_Q30)) >> 30;
      p    = 64'd1 << 30;
      for (int k = 9; k >= 1; k--) p = (64'd1 << 30) - ((t * p) >> 30) / k;
      if (n > 30) return 0;
      return p >> n;
    endfunction

    function void note_point(logic [31:0] ea, logic [31:0] eb, logic [31:0] q, logic lp);
      logic signed [63:0] a, b, d, sum, half;
      logic [63:0] dm, sq, x, cap, v2, dd, dsq, cterm, s;
      logic [127:0] prod;
      energy_exp_t e;
      a   = 64'(signed'(ea));
      b   = 64'(signed'(eb));
      d   = 64'(signed'(q)) - 64'(signed'(ref_q));
      dm  = d < 0 ? -d : d;
      sq  = (dm * dm) >> FRAC_BITS;
      cap = 64'd64 << FRAC_BITS;
      prod = 128'(width) * 128'(sq);
      // A product beyond 64 bits clamps just like a large exponent.
      if (prod[127:64] != 0) x = cap;
      else x = prod[63:0] >> FRAC_BITS;
      if (x > cap) x = cap;
      v2    = (64'(peak) * decay_q30(x)) >> 30;
      d     = a - b;
      dd    = d < 0 ? -d : d;
      dsq   = dd * dd;
      cterm = v2 << (FRAC_BITS + 2);
      if (dsq > ~64'd0 - cterm) s = 2 * root64((dsq >> 2) + (cterm >> 2));
      else s = root64(dsq + cterm);
      sum  = a + b - signed'(s);
      half = sum >>> 1;
      if (half > 64'sd2147483647) half = 64'sd2147483647;
      if (half < -64'sd2147483648) half = -64'sd2147483648;
      e.ground = half[31:0];
      e.coord  = q;
      e.last   = lp;
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] g, logic [31:0] q, logic lo);
      energy_exp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result ground_energy=%h", g);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g !== e.ground) begin
        $error("ground_energy expected %h actual %h", e.ground, g);
        errors++;
      end
      if (q !== e.coord) begin
        $error("coord_out expected %h actual %h", e.coord, q);
        errors++;
      end
      if (lo !== e.last) begin
        $error("last_out expected %b actual %b", e.last, lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  tsge_in_if  point();
  tsge_out_if result();

  int   send_idle = 0;
  int   recv_stall = 0;
  int   hold_off;
  logic hold_go;

  energy_scoreboard sb = new();

  two_state_ground_energy DUT (
    .clk(clk), .rst(rst), .point(point), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (hold_go) begin
      hold_off <= 200;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else begin
      if (result.valid && result.ready)
        sb.check_result(result.ground_energy, result.coord_out, result.last_out);
      if (hold_off > 0) begin
        result.ready <= 0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    psel   <= 1;
    pwrite <= 1;
    paddr  <= 4'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (r)
      REG_PEAK:  sb.peak  = v;
      REG_WIDTH: sb.width = v;
      default:   sb.ref_q = v;
    endcase
  endtask

  task automatic send_point(input logic [31:0] ea, input logic [31:0] eb,
                            input logic [31:0] q, input logic lp);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      point.valid <= 0;
      @(posedge clk);
    end
    point.valid      <= 1;
    point.energy_a   <= ea;
    point.energy_b   <= eb;
    point.coord      <= q;
    point.last_point <= lp;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    sb.note_point(ea, eb, q, lp);
  endtask

  task automatic drain();
    int n;
    n = 0;
    point.valid <= 0;
    while (sb.pending.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_energy();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 20 << 16)) - (32'd10 << 16);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 4 << 16)) - (32'd2 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      default: return sb.ref_q + 32'($urandom_range(0, 8 << 16)) - (32'd4 << 16);
    endcase
  endfunction

  task automatic random_points(input int cnt);
    for (int i = 0; i < cnt; i++)
      send_point(pick_energy(), pick_energy(), pick_coord(), $urandom_range(1));
  endtask

  initial begin
    point.valid      <= 0;
    point.energy_a   <= 0;
    point.energy_b   <= 0;
    point.coord      <= 0;
    point.last_point <= 0;
    hold_go          <= 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, coincident energies, far and near coordinates.
    send_point(0, 0, 0, 0);
    send_point(32'h7fffffff, 32'h7fffffff, 0, 1);
    send_point(32'h80000000, 32'h80000000, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_point(32'h00010000, 32'hffff0000, 32'h00008000, 1);
    send_point(32'h00020000, 32'h00020000, 32'h00100000, 0);
    send_point(32'hffffffff, 32'hfffffffe, 32'hffffffff, 1);
    drain();
    write_reg(REG_PEAK, 32'hffffffff);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_REF, 32'h80000000);
    send_point(0, 0, 32'h80000000, 0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
    send_point(32'h80000000, 32'h80000000, 0, 0);
    send_point(32'h12345678, 32'h87654321, 32'h00000001, 1);
    drain();
    write_reg(REG_WIDTH, 32'hffffffff);
    write_reg(REG_REF, 32'h7fffffff);
    send_point(0, 0, 32'h7fffffff, 0);
    send_point(0, 0, 32'h7ffffff0, 1);
    send_point(0, 0, 32'h80000000, 0);
    drain();

    // Random phases across settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      case (ph)
        0: begin write_reg(REG_PEAK, 6554); write_reg(REG_WIDTH, 6554);
                 write_reg(REG_REF, 0); end
        1: begin write_reg(REG_PEAK, 32'd0); write_reg(REG_WIDTH, 32'h00010000); end
        2: begin write_reg(REG_PEAK, 32'h00100000); write_reg(REG_REF, 32'hfffe0000); end
        3: begin write_reg(REG_PEAK, $urandom()); write_reg(REG_WIDTH, $urandom()); end
        4: begin write_reg(REG_WIDTH, 32'd1); write_reg(REG_REF, $urandom()); end
        5: begin write_reg(REG_PEAK, 32'hffffffff); write_reg(REG_WIDTH, 32'h00004000); end
        6: begin write_reg(REG_PEAK, $urandom_range(1 << 20)); write_reg(REG_REF, 0); end
        default: begin write_reg(REG_PEAK, $urandom()); write_reg(REG_WIDTH, $urandom_range(1 << 18)); end
      endcase
      if (ph == 2) begin
        hold_go <= 1;
        @(posedge clk);
        hold_go <= 0;
      end
      random_points(140);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: sim.f
design/tsge_pkg.sv
design/tsge_if.sv
design/tsge_horner_step.sv
design/two_state_ground_energy.sv
design/tsge_checker.sv
tb/two_state_ground_energy_tb.sv
